// ===== hw/rtl/pdc_pkg.sv =====
// pdc_pkg: shared types and constants of the distinct tuple counter
// request and result structs, fixed field widths, engine status struct
// no dependencies
`default_nettype none

package pdc_pkg;

    // fixed row layout
    localparam int COLUMNS    = 5;
    localparam int VALUE_BITS = 8;
    localparam int TUPLE_BITS = COLUMNS * VALUE_BITS;
    localparam int MASK_BITS  = 5;
    localparam int COUNT_BITS = 11;

    // table entry tag, slot is live when its tag equals the current epoch
    localparam int EPOCH_BITS = 8;

    localparam logic [MASK_BITS-1:0]  MASK_RESET = 5'd31;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FREE = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

    // one table row request
    typedef struct packed {
        logic                  first_row;
        logic [VALUE_BITS-1:0] col_0;
        logic [VALUE_BITS-1:0] col_1;
        logic [VALUE_BITS-1:0] col_2;
        logic [VALUE_BITS-1:0] col_3;
        logic [VALUE_BITS-1:0] col_4;
    } in_req_t;

    // one result request
    typedef struct packed {
        logic [COUNT_BITS-1:0] distinct_count;
        logic                  set_overflow;
    } out_res_t;

    // engine status toward the front
    typedef struct packed {
        logic clearing;
    } eng_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdc_ram.sv =====
// pdc_ram: generic single write port, single read port memory
// read data is registered, valid in the cycle after the read address
// no dependencies
`default_nettype none

module pdc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pdc_front.sv =====
// pdc_front: projects an incoming row through the column mask and hashes it
// produces the projected tuple and its home slot in the table
// depends on pdc_pkg
`default_nettype none

module pdc_front #(
    parameter int TABLE_BITS = 11
) (
    input  wire pdc_pkg::in_req_t                  row,
    input  wire logic [pdc_pkg::MASK_BITS-1:0]     mask,
    output logic      [pdc_pkg::TUPLE_BITS-1:0]    tuple,
    output logic      [TABLE_BITS-1:0]             hash
);

    import pdc_pkg::*;

    localparam int NCHUNK = (TUPLE_BITS + TABLE_BITS - 1) / TABLE_BITS;

    logic [VALUE_BITS-1:0]        cols [COLUMNS];
    logic [NCHUNK*TABLE_BITS-1:0] padded;

    // columns outside the mask read as zero
    always_comb
    begin
        cols[0] = mask[0] ? row.col_0 : '0;
        cols[1] = mask[1] ? row.col_1 : '0;
        cols[2] = mask[2] ? row.col_2 : '0;
        cols[3] = mask[3] ? row.col_3 : '0;
        cols[4] = mask[4] ? row.col_4 : '0;
        tuple   = {cols[4], cols[3], cols[2], cols[1], cols[0]};
    end

    // xor fold of the tuple down to a slot index
    always_comb
    begin
        padded = '0;
        padded[TUPLE_BITS-1:0] = tuple;
        hash = '0;
        for (int j = 0; j < NCHUNK; j++)
        begin
            hash = hash ^ padded[j*TABLE_BITS +: TABLE_BITS];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pdc_queue.sv =====
// pdc_queue: two entry request queue between front and engine
// lets the front accept while the engine is probing
// no dependencies
`default_nettype none

module pdc_queue #(
    parameter int WIDTH = 52
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pdc_engine.sv =====
// pdc_engine: linear probing set over an epoch tagged table memory
// probes, inserts, counts, sweeps the table, and holds the result register
// depends on pdc_pkg and pdc_ram
`default_nettype none

module pdc_engine #(
    parameter int CAPACITY   = 1024,
    parameter int TABLE_BITS = 11
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_valid,
    input  wire logic [1+TABLE_BITS+pdc_pkg::TUPLE_BITS-1:0] q_data,
    output logic                                       q_pop,
    output pdc_pkg::eng_status_t                       status,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output pdc_pkg::out_res_t                          result
);

    import pdc_pkg::*;

    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int ENTRY_BITS  = EPOCH_BITS + TUPLE_BITS;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [TABLE_BITS-1:0] slot_reg, slot_next;
    logic [TABLE_BITS-1:0] clr_reg, clr_next;
    logic                  pending_reg, pending_next;
    logic [TUPLE_BITS-1:0] tuple_reg, tuple_next;
    logic                  out_valid_reg, out_valid_next;
    out_res_t              out_reg, out_next;

    logic                  q_first;
    logic [TABLE_BITS-1:0] q_hash;
    logic [TUPLE_BITS-1:0] q_tuple;

    logic                  wr_en, rd_en;
    logic [TABLE_BITS-1:0] wr_addr, rd_addr;
    logic [ENTRY_BITS-1:0] wr_data, rd_data;
    logic [EPOCH_BITS-1:0] rd_epoch;
    logic [TUPLE_BITS-1:0] rd_tuple;
    logic                  out_free, finish;

    assign q_first = q_data[TABLE_BITS+TUPLE_BITS];
    assign q_hash  = q_data[TABLE_BITS+TUPLE_BITS-1:TUPLE_BITS];
    assign q_tuple = q_data[TUPLE_BITS-1:0];

    assign rd_epoch = rd_data[ENTRY_BITS-1:TUPLE_BITS];
    assign rd_tuple = rd_data[TUPLE_BITS-1:0];

    assign out_free        = !out_valid_reg || result_ready;
    assign status.clearing = (state_reg == S_CLEAR);
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    pdc_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // probe sequencer
    always_comb
    begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        pending_next = pending_reg;
        tuple_next   = tuple_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = {epoch_reg, tuple_reg};
        rd_en        = 1'b0;
        rd_addr      = slot_reg;
        finish       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // free every slot, one per cycle
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = {EPOCH_FREE, {TUPLE_BITS{1'b0}}};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {TABLE_BITS{1'b1}})
                begin
                    epoch_next   = EPOCH_FREE + 1'b1;
                    pending_next = 1'b0;
                    state_next   = pending_reg ? S_ISSUE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    tuple_next = q_tuple;
                    slot_next  = q_hash;
                    rd_addr    = q_hash;
                    state_next = S_PROBE;
                    rd_en      = 1'b1;
                    if (q_first)
                    begin
                        count_next = '0;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            // tags would wrap, sweep the table first
                            rd_en        = 1'b0;
                            clr_next     = '0;
                            pending_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            S_ISSUE:
            begin
                rd_en      = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (rd_epoch == epoch_reg && rd_tuple == tuple_reg)
                begin
                    finish = 1'b1;
                end
                else if (rd_epoch != epoch_reg)
                begin
                    // free slot: insert if room is left
                    finish = 1'b1;
                    if (count_reg < CNT_BITS'(CAPACITY))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    // occupied by another tuple, step to the next slot
                    slot_next = slot_reg + 1'b1;
                    rd_addr   = slot_reg + 1'b1;
                    rd_en     = 1'b1;
                end
                if (finish)
                begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                finish = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (finish && out_free)
        begin
            out_valid_next          = 1'b1;
            out_next.distinct_count = COUNT_BITS'(count_next);
            out_next.set_overflow   = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            epoch_reg     <= EPOCH_FREE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        tuple_reg <= tuple_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/projected_tuple_distinct_count.sv =====
// projected_tuple_distinct_count: top level of the distinct tuple counter
// ties the column mask register, front, request queue and probe engine
// depends on pdc_pkg, pdc_front, pdc_queue, pdc_engine
`default_nettype none

// Counts distinct projected tuples in a stream of five column rows. Each
// accepted row request yields one result request with the running distinct
// count and a sticky overflow flag; a row with first_row set starts a new
// set. Rows go through a two entry queue into a probe engine that keeps the
// set in one table memory of 2^(clog2(CAPACITY)+1) slots with linear probing,
// one read and one write port. In the engine a row takes an issue step and
// a probe step, plus one more probe for every occupied slot passed; the
// table is at most half full. The engine takes the next row only once it
// is through with the last. After reset the engine sweeps the whole table,
// one slot per cycle, before it accepts any row. Slots carry an 8 bit epoch
// tag that moves on each first row; every 255th first row repeats that sweep.
// The column mask register should only be written while the block is idle.
module projected_tuple_distinct_count #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          row_valid,
    output logic                               row_ready,
    input  wire pdc_pkg::in_req_t              row,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output pdc_pkg::out_res_t                  result,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pdc_pkg::MASK_BITS-1:0] cfg_wr_data
);

    import pdc_pkg::*;

    localparam int TABLE_BITS = $clog2(CAPACITY) + 1;
    localparam int QW         = 1 + TABLE_BITS + TUPLE_BITS;

    logic [MASK_BITS-1:0]  mask_reg;
    logic [TUPLE_BITS-1:0] tuple;
    logic [TABLE_BITS-1:0] hash;
    logic                  q_full, q_valid, q_pop;
    logic [QW-1:0]         q_data;
    eng_status_t           status;

    // column mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    // no rows while the table sweep runs
    assign row_ready = !q_full && !status.clearing;

    pdc_front #(
        .TABLE_BITS(TABLE_BITS)
    ) u_front (
        .row  (row),
        .mask (mask_reg),
        .tuple(tuple),
        .hash (hash)
    );

    pdc_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (row_valid && row_ready),
        .push_data({row.first_row, hash, tuple}),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_data)
    );

    pdc_engine #(
        .CAPACITY  (CAPACITY),
        .TABLE_BITS(TABLE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .status      (status),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pdc_checker.sv =====
// pdc_checker: port level assertions for the distinct tuple counter
// bound onto projected_tuple_distinct_count; depends on pdc_pkg
`default_nettype none

module pdc_checker #(
    parameter int CAPACITY = 1024
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              row_valid,
    input wire logic              row_ready,
    input wire pdc_pkg::in_req_t  row,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire pdc_pkg::out_res_t result
);

    import pdc_pkg::*;

    localparam bit COUNT_FITS = (CAPACITY < (1 << COUNT_BITS));

    logic ovf_seen_reg;

    // remember an overflow once it has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_seen_reg <= 1'b0;
        end
        else if (result_valid && result_ready && result.set_overflow)
        begin
            ovf_seen_reg <= 1'b1;
        end
    end

    // a stalled row request holds
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row))
        else $error("row request dropped or changed while stalled");

    // a stalled result request holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result request dropped or changed while stalled");

    // overflow flag is sticky across results
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ovf_seen_reg |-> result.set_overflow)
        else $error("overflow flag cleared after it was reported");

    // every row leaves the set nonempty, so the count is not zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && COUNT_FITS |-> result.distinct_count != '0)
        else $error("distinct count of zero after a row");

endmodule

bind projected_tuple_distinct_count pdc_checker #(.CAPACITY(CAPACITY)) u_pdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_valid   (row_valid),
    .row_ready   (row_ready),
    .row         (row),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

`default_nettype wire
